// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property whose consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/rem_pkg.sv =====
package rem_pkg;

    // field widths of the stream payload
    localparam int SAMPLE_W        = 16;
    localparam int MSE_W           = 32;
    localparam int MAE_W           = 16;
    localparam int RMSE_W          = MSE_W / 2;
    localparam int R2_W            = 20;
    localparam int R2_FRAC         = 16;
    localparam int COUNT_W         = 13;
    localparam int MAX_SAMPLES_DEF = 4096;

    // square root runs one result bit per step
    localparam int SQRT_STEPS = RMSE_W;
    localparam int SQRT_CW    = $clog2(SQRT_STEPS);

    // r2 constants: 1.0 and the -8.0 clamp
    localparam int R2_ONE = 1 << R2_FRAC;
    localparam logic [R2_W-1:0] R2_MIN = {1'b1, {(R2_W-1){1'b0}}};

    // multiplier operations
    localparam logic [1:0] MUL_OP_NYY = 2'd0;
    localparam logic [1:0] MUL_OP_SY2 = 2'd1;
    localparam logic [1:0] MUL_OP_NUM = 2'd2;

    // divider operations
    localparam logic [1:0] DIV_OP_MSE = 2'd0;
    localparam logic [1:0] DIV_OP_MAE = 2'd1;
    localparam logic [1:0] DIV_OP_R2  = 2'd2;

    typedef struct packed {
        logic       acc;
        logic       load_out;
        logic       mul_start;
        logic [1:0] mul_op;
        logic       div_start;
        logic [1:0] div_op;
        logic       sqrt_start;
        logic       den_load;
        logic       sat_check;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
        logic r2_skip;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/rem_ctrl.sv =====
`include "assert_macros.svh"

module rem_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    input  rem_pkg::dp_status_t   status,
    output logic                  s_tready,
    output rem_pkg::dp_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL_NYY = 4'd1;
    localparam logic [3:0] ST_MUL_SY2 = 4'd2;
    localparam logic [3:0] ST_MUL_NUM = 4'd3;
    localparam logic [3:0] ST_DIV_MSE = 4'd4;
    localparam logic [3:0] ST_DIV_MAE = 4'd5;
    localparam logic [3:0] ST_SQRT    = 4'd6;
    localparam logic [3:0] ST_DEN     = 4'd7;
    localparam logic [3:0] ST_SAT     = 4'd8;
    localparam logic [3:0] ST_DIV_R2  = 4'd9;
    localparam logic [3:0] ST_FIN     = 4'd10;
    localparam logic [3:0] ST_LAST    = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] unit_starts;

    // pairs are taken only while accumulating
    assign s_tready = (state_reg == ST_IDLE);

    // sequencing of the end-of-run arithmetic
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.acc = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = ST_LAST;
                    end
                end
            end
            ST_LAST:
            begin
                // sums now include the last pair
                state_next    = ST_MUL_NYY;
                cmd.mul_start = 1'b1;
                cmd.mul_op    = rem_pkg::MUL_OP_NYY;
            end
            ST_MUL_NYY:
            begin
                if (status.mul_done)
                begin
                    state_next    = ST_MUL_SY2;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = rem_pkg::MUL_OP_SY2;
                end
            end
            ST_MUL_SY2:
            begin
                if (status.mul_done)
                begin
                    state_next    = ST_MUL_NUM;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = rem_pkg::MUL_OP_NUM;
                end
            end
            ST_MUL_NUM:
            begin
                if (status.mul_done)
                begin
                    state_next    = ST_DIV_MSE;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = rem_pkg::DIV_OP_MSE;
                end
            end
            ST_DIV_MSE:
            begin
                if (status.div_done)
                begin
                    state_next    = ST_DIV_MAE;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = rem_pkg::DIV_OP_MAE;
                end
            end
            ST_DIV_MAE:
            begin
                if (status.div_done)
                begin
                    state_next     = ST_SQRT;
                    cmd.sqrt_start = 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                cmd.den_load = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat_check = 1'b1;
                if (status.r2_skip)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next    = ST_DIV_R2;
                    cmd.div_start = 1'b1;
                    cmd.div_op    = rem_pkg::DIV_OP_R2;
                end
            end
            ST_DIV_R2:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign unit_starts = {cmd.mul_start, cmd.div_start, cmd.sqrt_start};

    `ASSERT_RST(a_one_unit_start, clk, rst_n, $onehot0(unit_starts), "two units started")
    `ASSERT_NEXT(a_fin_reopens, clk, rst_n, cmd.load_out, s_tready, "input not reopened")
    `ASSERT_RST(a_acc_when_ready, clk, rst_n, (!cmd.acc || s_tready), "pair taken while busy")

endmodule

// ===== hw/rtl/rem_dp.sv =====
`include "assert_macros.svh"

module rem_dp #(
    parameter int MAX_SAMPLES = rem_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rem_pkg::dp_cmd_t                     cmd,
    output rem_pkg::dp_status_t                  status,
    input  logic signed [rem_pkg::SAMPLE_W-1:0]  pred_value,
    input  logic signed [rem_pkg::SAMPLE_W-1:0]  true_value,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [rem_pkg::MSE_W-1:0]            mse,
    output logic [rem_pkg::MAE_W-1:0]            mae,
    output logic [rem_pkg::RMSE_W-1:0]           rmse,
    output logic signed [rem_pkg::R2_W-1:0]      r2,
    output logic [rem_pkg::COUNT_W-1:0]          sample_count,
    output logic                                 no_variance,
    output logic                                 r2_saturated,
    output logic                                 overflow
);

    localparam int SW    = rem_pkg::SAMPLE_W;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int ERR_W = SW + 1;
    localparam int SSE_W = 2 * ERR_W + CW;
    localparam int SAE_W = ERR_W + CW;
    localparam int SY_W  = SW + CW + 1;
    localparam int SYY_W = 2 * SW + CW;
    localparam int PW    = 2 * ERR_W + 2 * CW;
    localparam int BW    = SY_W;
    localparam int DW    = PW + rem_pkg::R2_FRAC;
    localparam int MCW   = $clog2(BW);
    localparam int DCW   = $clog2(DW);
    localparam int QW    = rem_pkg::RMSE_W;
    localparam int R2W   = rem_pkg::R2_W;

    // run accumulators
    logic [CW-1:0]    cnt_reg;
    logic [SSE_W-1:0] sse_reg;
    logic [SAE_W-1:0] sae_reg;
    logic [SY_W-1:0]  sy_reg;
    logic [SYY_W-1:0] syy_reg;
    logic             ovf_reg;

    logic [SW-1:0]     p_bits;
    logic [SW-1:0]     t_bits;
    logic [ERR_W-1:0]  err;
    logic [ERR_W-1:0]  abs_err;
    logic [SW-1:0]     abs_t;
    logic [2*ERR_W-1:0] sq_err;
    logic [2*SW-1:0]   sq_t;

    assign p_bits  = pred_value;
    assign t_bits  = true_value;
    assign err     = {p_bits[SW-1], p_bits} - {t_bits[SW-1], t_bits};
    assign abs_err = err[ERR_W-1] ? (~err + 1'b1) : err;
    assign abs_t   = t_bits[SW-1] ? (~t_bits + 1'b1) : t_bits;
    assign sq_err  = abs_err * abs_err;
    assign sq_t    = abs_t * abs_t;

    // accumulate one pair, clear when the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sse_reg <= '0;
            sae_reg <= '0;
            sy_reg  <= '0;
            syy_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            cnt_reg <= '0;
            sse_reg <= '0;
            sae_reg <= '0;
            sy_reg  <= '0;
            syy_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (cnt_reg < CW'(MAX_SAMPLES))
            begin
                cnt_reg <= cnt_reg + 1'b1;
                sse_reg <= sse_reg + SSE_W'(sq_err);
                sae_reg <= sae_reg + SAE_W'(abs_err);
                sy_reg  <= sy_reg + {{(SY_W-SW){t_bits[SW-1]}}, t_bits};
                syy_reg <= syy_reg + SYY_W'(sq_t);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    logic [SY_W-1:0] sy_mag;
    assign sy_mag = sy_reg[SY_W-1] ? (~sy_reg + 1'b1) : sy_reg;

    // shift-add multiplier, one multiplier bit per cycle
    logic [PW-1:0]  mul_a_reg;
    logic [BW-1:0]  mul_b_reg;
    logic [PW-1:0]  mul_p_reg;
    logic [MCW-1:0] mul_cnt_reg;
    logic           mul_busy_reg;
    logic [1:0]     mul_op_reg;
    logic [PW-1:0]  mul_a_start;
    logic [BW-1:0]  mul_b_start;
    logic [PW-1:0]  mul_sum;
    logic           mul_done;

    logic [PW-1:0]  nyy_reg;
    logic [PW-1:0]  sy2_reg;
    logic [PW-1:0]  num_reg;

    always_comb
    begin
        case (cmd.mul_op)
            rem_pkg::MUL_OP_NYY:
            begin
                mul_a_start = PW'(syy_reg);
                mul_b_start = BW'(cnt_reg);
            end
            rem_pkg::MUL_OP_SY2:
            begin
                mul_a_start = PW'(sy_mag);
                mul_b_start = sy_mag;
            end
            default:
            begin
                mul_a_start = PW'(sse_reg);
                mul_b_start = BW'(cnt_reg);
            end
        endcase
    end

    assign mul_sum  = mul_p_reg + (mul_b_reg[0] ? mul_a_reg : '0);
    assign mul_done = mul_busy_reg && (mul_cnt_reg == MCW'(BW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
        end
        else if (cmd.mul_start)
        begin
            mul_busy_reg <= 1'b1;
        end
        else if (mul_done)
        begin
            mul_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_a_reg   <= mul_a_start;
            mul_b_reg   <= mul_b_start;
            mul_p_reg   <= '0;
            mul_cnt_reg <= '0;
            mul_op_reg  <= cmd.mul_op;
        end
        else if (mul_busy_reg)
        begin
            mul_a_reg   <= {mul_a_reg[PW-2:0], 1'b0};
            mul_b_reg   <= {1'b0, mul_b_reg[BW-1:1]};
            mul_p_reg   <= mul_sum;
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
        if (mul_done)
        begin
            case (mul_op_reg)
                rem_pkg::MUL_OP_NYY: nyy_reg <= mul_sum;
                rem_pkg::MUL_OP_SY2: sy2_reg <= mul_sum;
                default:             num_reg <= mul_sum;
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [DW-1:0]  div_rem_reg;
    logic [DW-1:0]  div_quo_reg;
    logic [DW-1:0]  div_d_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           div_busy_reg;
    logic [1:0]     div_op_reg;
    logic [DW-1:0]  div_quo_start;
    logic [DW-1:0]  div_d_start;
    logic [DW:0]    div_trial;
    logic           div_ge;
    logic [DW-1:0]  div_rem_next;
    logic [DW-1:0]  div_quo_next;
    logic           div_done;
    logic [R2W:0]   r2_calc;

    logic [PW-1:0]  den_reg;

    always_comb
    begin
        case (cmd.div_op)
            rem_pkg::DIV_OP_MSE:
            begin
                div_quo_start = DW'(sse_reg);
                div_d_start   = DW'(cnt_reg);
            end
            rem_pkg::DIV_OP_MAE:
            begin
                div_quo_start = DW'(sae_reg);
                div_d_start   = DW'(cnt_reg);
            end
            default:
            begin
                div_quo_start = {num_reg, {rem_pkg::R2_FRAC{1'b0}}};
                div_d_start   = DW'(den_reg);
            end
        endcase
    end

    assign div_trial    = {div_rem_reg, div_quo_reg[DW-1]};
    assign div_ge       = div_trial >= {1'b0, div_d_reg};
    assign div_rem_next = div_ge ? DW'(div_trial - {1'b0, div_d_reg}) : DW'(div_trial);
    assign div_quo_next = {div_quo_reg[DW-2:0], div_ge};
    assign div_done     = div_busy_reg && (div_cnt_reg == DCW'(DW - 1));

    // r2 = 1 - ceil(num * 2^16 / den)
    assign r2_calc = (R2W+1)'(rem_pkg::R2_ONE) - (R2W+1)'(div_quo_next)
                   - (R2W+1)'(div_rem_next != '0);

    logic [rem_pkg::MSE_W-1:0] mse_reg;
    logic [rem_pkg::MAE_W-1:0] mae_reg;
    logic [QW-1:0]             rmse_reg;
    logic [R2W-1:0]            r2_reg;
    logic                      novar_reg;
    logic                      sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
        end
        else if (div_done)
        begin
            div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_rem_reg <= '0;
            div_quo_reg <= div_quo_start;
            div_d_reg   <= div_d_start;
            div_cnt_reg <= '0;
            div_op_reg  <= cmd.div_op;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // integer square root of mse, two radicand bits per step
    logic [rem_pkg::MSE_W-1:0]  sq_x_reg;
    logic [QW+1:0]              sq_rem_reg;
    logic [QW-1:0]              sq_root_reg;
    logic [rem_pkg::SQRT_CW-1:0] sq_cnt_reg;
    logic                       sq_busy_reg;
    logic [QW+3:0]              sq_trial;
    logic [QW+3:0]              sq_s;
    logic                       sq_ge;
    logic [QW-1:0]              sq_root_next;
    logic                       sq_done;

    assign sq_trial     = {sq_rem_reg, sq_x_reg[rem_pkg::MSE_W-1 -: 2]};
    assign sq_s         = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge        = sq_trial >= sq_s;
    assign sq_root_next = {sq_root_reg[QW-2:0], sq_ge};
    assign sq_done      = sq_busy_reg
                        && (sq_cnt_reg == rem_pkg::SQRT_CW'(rem_pkg::SQRT_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
        end
        else if (cmd.sqrt_start)
        begin
            sq_busy_reg <= 1'b1;
        end
        else if (sq_done)
        begin
            sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            sq_x_reg    <= mse_reg;
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
            sq_cnt_reg  <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_x_reg    <= {sq_x_reg[rem_pkg::MSE_W-3:0], 2'b00};
            sq_rem_reg  <= sq_ge ? (QW+2)'(sq_trial - sq_s) : (QW+2)'(sq_trial);
            sq_root_reg <= sq_root_next;
            sq_cnt_reg  <= sq_cnt_reg + 1'b1;
        end
    end

    // variance and clamp checks ahead of the r2 division
    logic [PW+3:0] nine_den;
    logic          sat_now;

    assign nine_den = (PW+4)'({den_reg, 3'b000}) + (PW+4)'(den_reg);
    assign sat_now  = !novar_reg && ((PW+4)'(num_reg) > nine_den);

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            novar_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.den_load)
            begin
                novar_reg <= (nyy_reg <= sy2_reg);
            end
            if (cmd.sat_check)
            begin
                sat_reg <= sat_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.den_load)
        begin
            den_reg <= nyy_reg - sy2_reg;
        end
        if (cmd.sat_check)
        begin
            r2_reg <= novar_reg ? '0 : (sat_now ? rem_pkg::R2_MIN : r2_reg);
        end
        if (sq_done)
        begin
            rmse_reg <= sq_root_next;
        end
        if (div_done)
        begin
            case (div_op_reg)
                rem_pkg::DIV_OP_MSE: mse_reg <= div_quo_next[rem_pkg::MSE_W-1:0];
                rem_pkg::DIV_OP_MAE: mae_reg <= div_quo_next[rem_pkg::MAE_W-1:0];
                default:             r2_reg  <= r2_calc[R2W-1:0];
            endcase
        end
    end

    // output register, holds while the receiver stalls
    logic                       out_valid_reg;
    logic [rem_pkg::MSE_W-1:0]  out_mse_reg;
    logic [rem_pkg::MAE_W-1:0]  out_mae_reg;
    logic [QW-1:0]              out_rmse_reg;
    logic [R2W-1:0]             out_r2_reg;
    logic [rem_pkg::COUNT_W-1:0] out_cnt_reg;
    logic                       out_novar_reg;
    logic                       out_sat_reg;
    logic                       out_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mse_reg   <= mse_reg;
            out_mae_reg   <= mae_reg;
            out_rmse_reg  <= rmse_reg;
            out_r2_reg    <= r2_reg;
            out_cnt_reg   <= rem_pkg::COUNT_W'(cnt_reg);
            out_novar_reg <= novar_reg;
            out_sat_reg   <= sat_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign mse          = out_mse_reg;
    assign mae          = out_mae_reg;
    assign rmse         = out_rmse_reg;
    assign r2           = out_r2_reg;
    assign sample_count = out_cnt_reg;
    assign no_variance  = out_novar_reg;
    assign r2_saturated = out_sat_reg;
    assign overflow     = out_ovf_reg;

    assign status.mul_done  = mul_done;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sq_done;
    assign status.r2_skip   = novar_reg || sat_now;
    assign status.out_free  = !out_valid_reg || m_tready;

    `ASSERT_RST(a_cnt_cap, clk, rst_n, (cnt_reg <= CW'(MAX_SAMPLES)), "pair count beyond capacity")
    `ASSERT_RST(a_load_when_free, clk, rst_n, (!cmd.load_out || status.out_free), "result overwritten")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, (m_tvalid && !m_tready), m_tvalid, "result dropped")

endmodule

// ===== hw/rtl/regression_error_metrics_unit.sv =====
// Regression error metrics over runs of (prediction, truth) sample pairs.
// Input stream: s_tdata carries pred_value and true_value, s_tlast marks
// the final pair of a run. Each pair is added to the sums as it is taken, so
// pairs stream at one per cycle while a run is in progress.
// After the last pair the block computes n*sum(y^2), sum(y)^2 and n*SSres
// on a shift-add multiplier with a SY_W-bit multiplier, mse and mae on a
// restoring divider of width DW, rmse on a bit-pair square root, then the
// r2 division (skipped for zero variance or clamp). At the default capacity
// SY_W = 30 and DW = 76; s_tready is low from the last pair until the
// result is loaded into the output register.
// Output stream: one request per run on m_tdata/m_tuser, held in an output
// register. The next run is accumulated while that request waits; if a run
// ends before the previous result is taken, the block holds off the input
// until m_tready frees the output register.
// Reset clears all sums, the count, the overflow flag and the output valid.
module regression_error_metrics_unit #(
    parameter int MAX_SAMPLES = rem_pkg::MAX_SAMPLES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // pred_value, true_value
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // mse, mae, rmse, r2, sample_count, zero pad
    output logic [2:0]   m_tuser    // no_variance, r2_saturated, overflow
);

    rem_pkg::dp_cmd_t    cmd;
    rem_pkg::dp_status_t status;

    logic signed [rem_pkg::SAMPLE_W-1:0] pred_value;
    logic signed [rem_pkg::SAMPLE_W-1:0] true_value;
    logic [rem_pkg::MSE_W-1:0]           mse;
    logic [rem_pkg::MAE_W-1:0]           mae;
    logic [rem_pkg::RMSE_W-1:0]          rmse;
    logic signed [rem_pkg::R2_W-1:0]     r2;
    logic [rem_pkg::COUNT_W-1:0]         sample_count;
    logic                                no_variance;
    logic                                r2_saturated;
    logic                                overflow;

    // unpack input request
    assign pred_value = s_tdata[15:0];
    assign true_value = s_tdata[31:16];

    rem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rem_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pred_value   (pred_value),
        .true_value   (true_value),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .mse          (mse),
        .mae          (mae),
        .rmse         (rmse),
        .r2           (r2),
        .sample_count (sample_count),
        .no_variance  (no_variance),
        .r2_saturated (r2_saturated),
        .overflow     (overflow)
    );

    // pack output request
    assign m_tdata = {7'b0, sample_count, r2, rmse, mae, mse};
    assign m_tuser = {overflow, r2_saturated, no_variance};

endmodule

// ===== bench/tb_regression_error_metrics_unit.sv =====
`timescale 1ns / 1ps

module tb_regression_error_metrics_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 600;
    localparam int CAPACITY       = rem_pkg::MAX_SAMPLES_DEF;

    typedef struct {
        logic signed [rem_pkg::SAMPLE_W-1:0] pred_value;
        logic signed [rem_pkg::SAMPLE_W-1:0] true_value;
        logic                                last;
        logic                                wait_drain;  // sender pauses until all results are back
    } pair_t;

    typedef struct {
        logic [rem_pkg::MSE_W-1:0]   mse;
        logic [rem_pkg::MAE_W-1:0]   mae;
        logic [rem_pkg::RMSE_W-1:0]  rmse;
        logic [rem_pkg::R2_W-1:0]    r2;
        logic [rem_pkg::COUNT_W-1:0] sample_count;
        logic                        no_variance;
        logic                        r2_saturated;
        logic                        overflow;
    } metrics_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0] m_tuser;

    regression_error_metrics_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pair_t    pending_pairs[$];
    metrics_t metrics_q[$];

    // running sums of the current run
    int                 run_count;
    longint unsigned    run_sq_err;
    longint unsigned    run_abs_err;
    longint             run_truth;
    longint unsigned    run_truth_sq;
    bit                 run_dropped;

    int pairs_sent;
    int results_seen;
    int mismatches;
    int n_novar;
    int n_sat;
    int n_ovf;
    int idle_cycles;
    int hold_left;
    bit hold_done;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [rem_pkg::RMSE_W-1:0] floor_sqrt(
        input logic [rem_pkg::MSE_W-1:0] x);
        logic [rem_pkg::RMSE_W-1:0] r;
        logic [rem_pkg::RMSE_W-1:0] trial;
        r = '0;
        for (int b = rem_pkg::RMSE_W - 1; b >= 0; b--) begin
            trial = r | (rem_pkg::RMSE_W'(1) << b);
            if (64'(trial) * 64'(trial) <= 64'(x))
                r = trial;
        end
        return r;
    endfunction

    // fold one pair into the run, queue the metrics when it closes the run
    task automatic accumulate_pair(input pair_t pr);
        longint e;
        longint t;
        longint unsigned ae;
        longint unsigned n;
        longint unsigned n_syy;
        longint unsigned sy2;
        longint unsigned num;
        longint unsigned den;
        logic [127:0] scaled;
        longint total;
        metrics_t m;
        t = longint'(pr.true_value);
        e = longint'(pr.pred_value) - t;
        if (run_count < CAPACITY) begin
            ae = (e < 0) ? -e : e;
            run_sq_err   += ae * ae;
            run_abs_err  += ae;
            run_truth    += t;
            run_truth_sq += longint'(t * t);
            run_count++;
        end
        else
            run_dropped = 1'b1;
        if (!pr.last)
            return;
        n = longint'(run_count);
        m.mse  = rem_pkg::MSE_W'(run_sq_err / n);
        m.mae  = rem_pkg::MAE_W'(run_abs_err / n);
        m.rmse = floor_sqrt(m.mse);
        m.sample_count = rem_pkg::COUNT_W'(n);
        m.overflow = run_dropped;
        m.no_variance = 1'b0;
        m.r2_saturated = 1'b0;
        n_syy = n * run_truth_sq;
        sy2 = longint'(run_truth) * longint'(run_truth);
        num = n * run_sq_err;
        if (n_syy <= sy2) begin
            m.no_variance = 1'b1;
            m.r2 = '0;
        end
        else begin
            den = n_syy - sy2;
            if (128'(num) > 128'(den) * 9) begin
                m.r2_saturated = 1'b1;
                m.r2 = rem_pkg::R2_MIN;
            end
            else begin
                // ceiling of num * 2^16 / den, subtracted from 1.0
                scaled = ((128'(num) << rem_pkg::R2_FRAC) + 128'(den) - 1) / 128'(den);
                total = longint'(rem_pkg::R2_ONE) - longint'(scaled);
                m.r2 = total[rem_pkg::R2_W-1:0];
            end
        end
        metrics_q.insert(metrics_q.size(), m);
        run_count = 0;
        run_sq_err = 0;
        run_abs_err = 0;
        run_truth = 0;
        run_truth_sq = 0;
        run_dropped = 1'b0;
    endtask

    function automatic int phase_of();
        return (pairs_sent / 200) % 4;
    endfunction

    // sender: idles by phase, honors drain pauses
    always @(posedge clk) begin
        pair_t pr;
        bit idle;
        int ph;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                pr = pending_pairs.pop_front();
                accumulate_pair(pr);
                pairs_sent++;
            end
            if (!s_tvalid || s_tready) begin
                ph = phase_of();
                idle = (ph == 1) ? ($urandom_range(99) < 77) :
                       (ph == 3) ? ($urandom_range(99) < 25) : 1'b0;
                if (pending_pairs.size() == 0 || idle ||
                    (pending_pairs[0].wait_drain && metrics_q.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end
                else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_pairs[0].true_value, pending_pairs[0].pred_value};
                    s_tlast  <= pending_pairs[0].last;
                end
            end
        end
    end

    // receiver: stalls by phase, one long hold-off, field compare
    always @(posedge clk) begin
        metrics_t got;
        metrics_t want;
        int ph;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.mse          = m_tdata[31:0];
                got.mae          = m_tdata[47:32];
                got.rmse         = m_tdata[63:48];
                got.r2           = m_tdata[83:64];
                got.sample_count = m_tdata[96:84];
                got.no_variance  = m_tuser[0];
                got.r2_saturated = m_tuser[1];
                got.overflow     = m_tuser[2];
                results_seen++;
                if (metrics_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: mse=%0d count=%0d", got.mse,
                                 got.sample_count);
                end
                else begin
                    want = metrics_q.pop_front();
                    n_novar += want.no_variance;
                    n_sat   += want.r2_saturated;
                    n_ovf   += want.overflow;
                    if (got.mse !== want.mse || got.mae !== want.mae ||
                        got.rmse !== want.rmse || got.r2 !== want.r2 ||
                        got.sample_count !== want.sample_count ||
                        got.no_variance !== want.no_variance ||
                        got.r2_saturated !== want.r2_saturated ||
                        got.overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d exp: mse=%0d mae=%0d rmse=%0d r2=%h",
                                     results_seen, want.mse, want.mae, want.rmse, want.r2);
                            $display("    n=%0d nv=%b sat=%b ovf=%b",
                                     want.sample_count, want.no_variance,
                                     want.r2_saturated, want.overflow);
                            $display("result %0d got: mse=%0d mae=%0d rmse=%0d r2=%h",
                                     results_seen, got.mse, got.mae, got.rmse, got.r2);
                            $display("    n=%0d nv=%b sat=%b ovf=%b",
                                     got.sample_count, got.no_variance,
                                     got.r2_saturated, got.overflow);
                        end
                    end
                end
            end
            if (!hold_done && pairs_sent >= 300) begin
                hold_done <= 1'b1;
                hold_left <= 1500;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else begin
                ph = phase_of();
                if (ph == 2)
                    m_tready <= ($urandom_range(99) >= 77);
                else if (ph == 3)
                    m_tready <= ($urandom_range(99) >= 25);
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_pair(input int p, input int t, input bit lst, input bit drain);
        pair_t pr;
        pr.pred_value = p[rem_pkg::SAMPLE_W-1:0];
        pr.true_value = t[rem_pkg::SAMPLE_W-1:0];
        pr.last = lst;
        pr.wait_drain = drain;
        pending_pairs.insert(pending_pairs.size(), pr);
    endtask

    function automatic int rand_sample();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    initial begin
        int total;
        int len;
        int kind;
        int t;
        int p;
        bit drain;
        run_count = 0;
        run_sq_err = 0;
        run_abs_err = 0;
        run_truth = 0;
        run_truth_sq = 0;
        run_dropped = 0;
        pairs_sent = 0;
        results_seen = 0;
        mismatches = 0;
        n_novar = 0;
        n_sat = 0;
        n_ovf = 0;
        idle_cycles = 0;
        hold_left = 0;
        hold_done = 0;

        // extremes of both samples, heavy error
        add_pair(32767, -32768, 0, 0);
        add_pair(-32768, 32767, 0, 0);
        add_pair(0, 0, 1, 0);
        // single-pair run has no variance
        add_pair(100, 100, 1, 0);
        add_pair(-1, -1, 1, 0);
        // constant truth, zero variance
        add_pair(5, 7, 0, 0);
        add_pair(9, 7, 0, 0);
        add_pair(-3, 7, 1, 0);
        // r2 exactly -8.0, not clamped
        add_pair(3, 0, 0, 0);
        add_pair(5, 2, 1, 0);
        // perfect prediction gives 1.0
        add_pair(1000, 1000, 0, 0);
        add_pair(-2000, -2000, 0, 0);
        add_pair(300, 300, 1, 0);
        // near fit with small errors
        add_pair(32767, 32766, 0, 0);
        add_pair(-32768, -32767, 0, 0);
        add_pair(12, 10, 0, 0);
        add_pair(-7, -9, 1, 0);
        // just past -8.0, clamped
        add_pair(4, 0, 0, 0);
        add_pair(5, 2, 1, 0);

        total = pending_pairs.size();
        while (total < 1150) begin
            drain = ($urandom_range(39) == 0) || (total > 600 && total < 640);
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            kind = $urandom_range(3);
            for (int i = 0; i < len; i++) begin
                case (kind)
                    0: begin
                        t = rand_sample();
                        p = rand_sample();
                    end
                    1: begin
                        t = rand_sample() / 2;
                        p = t + int'($urandom_range(64)) - 32;
                    end
                    2: begin
                        t = int'($urandom_range(200)) - 100;
                        p = int'($urandom_range(200)) - 100;
                    end
                    default: begin
                        t = rand_sample();
                        p = t + int'($urandom_range(4000)) - 2000;
                        if (p > 32767) p = 32767;
                        if (p < -32768) p = -32768;
                    end
                endcase
                add_pair(p, t, i == len - 1, drain && i == 0);
            end
            total += len;
        end

        wait (rst_n);
        wait (pending_pairs.size() == 0 && metrics_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d pairs in %0d runs under idle and stall phases",
                 pairs_sent, results_seen);
        $display("runs without variance %0d, clamped %0d, over capacity %0d",
                 n_novar, n_sat, n_ovf);
        if (mismatches == 0 && metrics_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

endmodule
